### hw/rtl/tle_pkg.sv
// Shared types and constants for the text terminal line editor.
`timescale 1ns / 1ps

package tle_pkg;

  localparam int COL_W    = 6;
  localparam int ROW_W    = 6;
  localparam int DIM_W    = 7;
  localparam int ADDR_W   = 12;
  localparam int LIDX_W   = 6;
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 2;
  localparam int ACT_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam int CELL_DEPTH = 1 << ADDR_W;

  localparam logic [LIDX_W-1:0] LINE_MAX = 6'd63;
  localparam logic [DIM_W-1:0]  MAX_COLS = 7'd64;
  localparam logic [DIM_W-1:0]  MAX_ROWS = 7'd64;
  localparam logic [DIM_W-1:0]  COLS_RST = 7'd64;
  localparam logic [DIM_W-1:0]  ROWS_RST = 7'd40;

  localparam logic [BYTE_W-1:0] CHR_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] CHR_BS  = 8'h08;
  localparam logic [BYTE_W-1:0] CHR_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CHR_CR  = 8'h0D;

  localparam logic [ACT_W-1:0] ACT_PRINT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_KEY   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS  = 2'd0,
    KIND_CONSOLE = 2'd1,
    KIND_CELL    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    MEM_NONE    = 3'd0,
    MEM_CLR_ALL = 3'd1,
    MEM_CLR_ROW = 3'd2,
    MEM_CLR_CUR = 3'd3,
    MEM_RD_LEFT = 3'd4,
    MEM_RD_REQ  = 3'd5
  } mem_op_t;

  typedef enum logic [1:0] {
    DSEL_ZERO = 2'd0,
    DSEL_LINE = 2'd1,
    DSEL_LF   = 2'd2,
    DSEL_CELL = 2'd3
  } dsel_t;

  typedef struct packed {
    logic    latch;
    logic    print;
    logic    step_left;
    logic    sweep_clr;
    logic    sweep_inc;
    mem_op_t mem_op;
    logic    line_store;
    logic    line_dec;
    logic    line_clr;
    logic    line_rd;
    logic    emit;
    kind_t   kind;
    dsel_t   dsel;
    logic    last;
  } tle_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0]  req_action;
    logic [BYTE_W-1:0] req_byte;
    logic              line_empty;
    logic              line_full;
    logic              line_last;
    logic              scroll;
    logic              row_end;
    logic              all_end;
    logic              col_zero;
    logic              cell_zero;
    logic              out_free;
    logic              rot_busy;
  } tle_status_t;

endpackage

### hw/rtl/tle_ctrl.sv
// Controller state machine for the text terminal line editor.
`timescale 1ns / 1ps

module tle_ctrl
  import tle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  tle_status_t st,
  output tle_cmd_t    cmd
);

  typedef enum logic [14:0] {
    ST_CLEAR    = 15'b000000000000001,
    ST_IDLE     = 15'b000000000000010,
    ST_DECODE   = 15'b000000000000100,
    ST_PRINT    = 15'b000000000001000,
    ST_ROWCLR   = 15'b000000000010000,
    ST_BS_LEFT  = 15'b000000000100000,
    ST_BS_CLR   = 15'b000000001000000,
    ST_BS_RD    = 15'b000000010000000,
    ST_BS_CHK   = 15'b000000100000000,
    ST_LN_RD    = 15'b000001000000000,
    ST_LN_EMIT  = 15'b000010000000000,
    ST_LF_EMIT  = 15'b000100000000000,
    ST_RD_ISSUE = 15'b001000000000000,
    ST_RD_EMIT  = 15'b010000000000000,
    ST_STATUS   = 15'b100000000000000
  } state_t;

  state_t state, state_next;
  logic   enter, enter_next;
  state_t after_print;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      enter <= 1'b0;
    end else begin
      state <= state_next;
      enter <= enter_next;
    end
  end

  // where a print goes once the cursor (and any scrolled row) is settled
  always_comb begin
    if (!enter) after_print = ST_STATUS;
    else if (st.line_empty) after_print = ST_LF_EMIT;
    else after_print = ST_LN_RD;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    enter_next = enter;
    // hold the input while the rotation is being reduced after a rows write
    in_ready   = (state == ST_IDLE) && !st.rot_busy;
    case (state)
      ST_CLEAR: begin
        cmd.mem_op = MEM_CLR_ALL;
        if (st.all_end) begin
          cmd.sweep_clr = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid && !st.rot_busy) begin
          cmd.latch  = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        enter_next = 1'b0;
        case (st.req_action)
          ACT_PRINT: state_next = ST_PRINT;
          ACT_KEY: begin
            if (st.req_byte == CHR_LF) begin
              enter_next = 1'b1;
              state_next = ST_PRINT;
            end else if (st.req_byte == CHR_BS) begin
              if (!st.line_empty) begin
                cmd.line_dec = 1'b1;
                state_next   = ST_BS_LEFT;
              end else begin
                state_next = ST_STATUS;
              end
            end else if (st.req_byte != CHR_NUL && !st.line_full) begin
              cmd.line_store = 1'b1;
              state_next     = ST_PRINT;
            end else begin
              state_next = ST_STATUS;
            end
          end
          ACT_READ: state_next = ST_RD_ISSUE;
          default:  state_next = ST_STATUS;
        endcase
      end
      ST_PRINT: begin
        cmd.print     = 1'b1;
        cmd.sweep_clr = 1'b1;
        state_next    = st.scroll ? ST_ROWCLR : after_print;
      end
      ST_ROWCLR: begin
        cmd.mem_op = MEM_CLR_ROW;
        if (st.row_end) begin
          cmd.sweep_clr = 1'b1;
          state_next    = after_print;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      ST_LN_RD: begin
        cmd.line_rd = 1'b1;
        state_next  = ST_LN_EMIT;
      end
      ST_LN_EMIT: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = KIND_CONSOLE;
          cmd.dsel      = DSEL_LINE;
          cmd.sweep_inc = 1'b1;
          state_next    = st.line_last ? ST_LF_EMIT : ST_LN_RD;
        end
      end
      ST_LF_EMIT: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.kind     = KIND_CONSOLE;
          cmd.dsel     = DSEL_LF;
          cmd.last     = 1'b1;
          cmd.line_clr = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_BS_LEFT: begin
        cmd.step_left = 1'b1;
        state_next    = ST_BS_CLR;
      end
      ST_BS_CLR: begin
        cmd.mem_op = MEM_CLR_CUR;
        state_next = ST_BS_RD;
      end
      ST_BS_RD: begin
        if (st.col_zero) begin
          state_next = ST_STATUS;
        end else begin
          cmd.mem_op = MEM_RD_LEFT;
          state_next = ST_BS_CHK;
        end
      end
      ST_BS_CHK: state_next = st.cell_zero ? ST_BS_LEFT : ST_STATUS;
      ST_RD_ISSUE: begin
        cmd.mem_op = MEM_RD_REQ;
        state_next = ST_RD_EMIT;
      end
      ST_RD_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_CELL;
          cmd.dsel   = DSEL_CELL;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_STATUS: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_STATUS;
          cmd.dsel   = DSEL_ZERO;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/tle_datapath.sv
// Datapath: screen and line memories, cursor, rotation, geometry and result register.
`timescale 1ns / 1ps

module tle_datapath
  import tle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  tle_cmd_t             cmd,
  output tle_status_t          st,
  input  logic [ACT_W-1:0]     in_action,
  input  logic [BYTE_W-1:0]    in_byte,
  input  logic [COL_W-1:0]     in_col,
  input  logic [ROW_W-1:0]     in_row,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    out_kind,
  output logic [BYTE_W-1:0]    out_data,
  output logic [COL_W-1:0]     out_col,
  output logic [ROW_W-1:0]     out_row,
  output logic                 out_atc,
  output logic                 out_last
);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] vmax);
    logic [DIM_W-1:0] r;
    if (v == '0) r = 7'd1;
    else if (v > vmax) r = vmax;
    else r = v;
    return r;
  endfunction

  logic [BYTE_W-1:0] cells [CELL_DEPTH];
  logic [BYTE_W-1:0] line_mem [LINE_MAX];

  logic [DIM_W-1:0]  columns, columns_next, rows, rows_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next, rotation, rotation_next;
  logic              rot_fix, rot_fix_next;
  logic [LIDX_W-1:0] line_count, line_count_next;
  logic [ADDR_W-1:0] sweep;
  logic [ACT_W-1:0]  req_action;
  logic [BYTE_W-1:0] req_byte;
  logic [COL_W-1:0]  req_col;
  logic [ROW_W-1:0]  req_row;
  logic [BYTE_W-1:0] mem_q, line_q;

  logic [DIM_W-1:0]  col_inc, row_inc, rot_inc, sum_cur, sum_req, rot_sub;
  logic [DIM_W-1:0]  sum_cur_wrap, sum_req_wrap, nw, nh, nw_m1, nh_m1, cols_m1;
  logic [ROW_W-1:0]  phys_cur, phys_req, rot_step;
  logic              wrap, at_bottom, print_char, req_inb;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [BYTE_W-1:0] mem_wdata, emit_data;
  logic [DIM_W-1:0]  line_next_idx;

  assign col_inc    = {1'b0, cur_col} + 7'd1;
  assign row_inc    = {1'b0, cur_row} + 7'd1;
  assign rot_inc    = {1'b0, rotation} + 7'd1;
  assign rot_sub    = {1'b0, rotation} - rows;
  assign wrap       = col_inc >= columns;
  assign at_bottom  = row_inc >= rows;
  assign rot_step   = (rot_inc == rows) ? '0 : rot_inc[ROW_W-1:0];
  assign print_char = (req_byte != CHR_CR) && (req_byte != CHR_LF) && (req_byte != CHR_BS);
  assign cols_m1    = columns - 7'd1;

  // visible row to physical row through the rotation offset
  assign sum_cur      = {1'b0, cur_row} + {1'b0, rotation};
  assign sum_cur_wrap = (sum_cur >= rows) ? sum_cur - rows : sum_cur;
  assign phys_cur     = sum_cur_wrap[ROW_W-1:0];
  assign sum_req      = {1'b0, req_row} + {1'b0, rotation};
  assign sum_req_wrap = (sum_req >= rows) ? sum_req - rows : sum_req;
  assign phys_req     = sum_req_wrap[ROW_W-1:0];
  assign req_inb      = ({1'b0, req_col} < columns) && ({1'b0, req_row} < rows);

  assign nw    = clamp_dim(cfg_data, MAX_COLS);
  assign nh    = clamp_dim(cfg_data, MAX_ROWS);
  assign nw_m1 = nw - 7'd1;
  assign nh_m1 = nh - 7'd1;

  always_comb begin
    columns_next  = columns;
    rows_next     = rows;
    cur_col_next  = cur_col;
    cur_row_next  = cur_row;
    rotation_next = rotation;
    rot_fix_next  = rot_fix;
    if (cfg_we) begin
      if (cfg_index == REG_COLUMNS) begin
        columns_next = nw;
        if ({1'b0, cur_col} >= nw) cur_col_next = nw_m1[COL_W-1:0];
      end else begin
        rows_next    = nh;
        rot_fix_next = 1'b1;
        if ({1'b0, cur_row} >= nh) cur_row_next = nh_m1[ROW_W-1:0];
      end
    end else if (rot_fix) begin
      // reduce rotation into new row count, one subtraction per cycle unless cfg_we
      if ({1'b0, rotation} >= rows) rotation_next = rot_sub[ROW_W-1:0];
      else rot_fix_next = 1'b0;
    end else if (cmd.print) begin
      case (req_byte)
        CHR_CR: cur_col_next = '0;
        CHR_LF: begin
          cur_col_next = '0;
          if (at_bottom) rotation_next = rot_step;
          else cur_row_next = row_inc[ROW_W-1:0];
        end
        CHR_BS: begin
          if (cur_col != '0) cur_col_next = cur_col - 6'd1;
        end
        default: begin
          if (wrap) begin
            cur_col_next = '0;
            if (at_bottom) rotation_next = rot_step;
            else cur_row_next = row_inc[ROW_W-1:0];
          end else begin
            cur_col_next = col_inc[COL_W-1:0];
          end
        end
      endcase
    end else if (cmd.step_left) begin
      if (cur_col == '0) begin
        cur_col_next = cols_m1[COL_W-1:0];
        if (cur_row != '0) cur_row_next = cur_row - 6'd1;
      end else begin
        cur_col_next = cur_col - 6'd1;
      end
    end
  end

  always_comb begin
    line_count_next = line_count;
    if (cmd.line_clr) line_count_next = '0;
    else if (cmd.line_dec) line_count_next = line_count - 6'd1;
    else if (cmd.line_store) line_count_next = line_count + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns    <= COLS_RST;
      rows       <= ROWS_RST;
      cur_col    <= '0;
      cur_row    <= '0;
      rotation   <= '0;
      rot_fix    <= 1'b0;
      line_count <= '0;
      sweep      <= '0;
    end else begin
      columns    <= columns_next;
      rows       <= rows_next;
      cur_col    <= cur_col_next;
      cur_row    <= cur_row_next;
      rotation   <= rotation_next;
      rot_fix    <= rot_fix_next;
      line_count <= line_count_next;
      if (cmd.sweep_clr) sweep <= '0;
      else if (cmd.sweep_inc) sweep <= sweep + 12'd1;
    end
  end

  // hold the request; a key CR is taken as LF
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_action <= in_action;
      req_byte   <= (in_action == ACT_KEY && in_byte == CHR_CR) ? CHR_LF : in_byte;
      req_col    <= in_col;
      req_row    <= in_row;
    end
  end

  // single-port screen memory
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = '0;
    mem_addr  = {phys_cur, cur_col};
    case (cmd.mem_op)
      MEM_CLR_ALL: begin
        mem_we   = 1'b1;
        mem_addr = sweep;
      end
      MEM_CLR_ROW: begin
        mem_we   = 1'b1;
        mem_addr = {phys_cur, sweep[COL_W-1:0]};
      end
      MEM_CLR_CUR: mem_we = 1'b1;
      MEM_RD_LEFT: begin
        mem_re   = 1'b1;
        mem_addr = {phys_cur, cur_col - 6'd1};
      end
      MEM_RD_REQ: begin
        mem_re   = 1'b1;
        mem_addr = {phys_req, req_col};
      end
      default: begin
        if (cmd.print && print_char) begin
          mem_we    = 1'b1;
          mem_wdata = req_byte;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) cells[mem_addr] <= mem_wdata;
    if (mem_re) mem_q <= cells[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.line_store) line_mem[line_count] <= req_byte;
    if (cmd.line_rd) line_q <= line_mem[sweep[LIDX_W-1:0]];
  end

  always_comb begin
    case (cmd.dsel)
      DSEL_LINE: emit_data = line_q;
      DSEL_LF:   emit_data = CHR_LF;
      DSEL_CELL: emit_data = req_inb ? mem_q : CHR_NUL;
      default:   emit_data = CHR_NUL;
    endcase
  end

  // result register: a finished result waits here for the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind <= cmd.kind;
      out_data <= emit_data;
      out_col  <= cur_col;
      out_row  <= cur_row;
      out_atc  <= (cmd.dsel == DSEL_CELL) && req_inb &&
                  (req_col == cur_col) && (req_row == cur_row);
      out_last <= cmd.last;
    end
  end

  assign line_next_idx = {1'b0, sweep[LIDX_W-1:0]} + 7'd1;

  assign st.req_action = req_action;
  assign st.req_byte   = req_byte;
  assign st.line_empty = (line_count == '0);
  assign st.line_full  = (line_count == LINE_MAX);
  assign st.line_last  = (line_next_idx == {1'b0, line_count});
  assign st.scroll     = at_bottom && ((req_byte == CHR_LF) || (print_char && wrap));
  assign st.row_end    = ({1'b0, sweep[COL_W-1:0]} == cols_m1);
  assign st.all_end    = &sweep;
  assign st.col_zero   = (cur_col == '0);
  assign st.cell_zero  = (mem_q == CHR_NUL);
  assign st.out_free   = !out_valid || out_ready;
  assign st.rot_busy   = rot_fix;

endmodule

### hw/rtl/text_terminal_line_editor_unit.sv
// Status results are registered after the decode and status states, read results after the
// decode, memory read and emit states; a print that scrolls also clears the new bottom row
// column by column, and a key backspace steps left, clears, reads and checks per erased cell.
// Enter does any row clear, emits each stored byte, then the newline. Throughput: one item at
// a time. Reset (rst, synchronous): a clearing pass zeroes all 4096 cells, one per cycle,
// before the first item; a rows write holds the input while the rotation is reduced.
`timescale 1ns / 1ps

module text_terminal_line_editor_unit
  import tle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // byte_req[7:0], col[13:8], row[19:14], zero pad
  input  logic [ACT_W-1:0]     s_tuser,   // action[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // data[7:0], cursor_col[13:8], cursor_row[19:14],
                                          // at_cursor[20], zero pad
  output logic [KIND_W-1:0]    m_tuser,   // kind[1:0]
  output logic                 m_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  tle_cmd_t          cmd;
  tle_status_t       st;
  logic [BYTE_W-1:0] out_data;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;
  logic              out_atc;

  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tle_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_action (s_tuser),
    .in_byte   (s_tdata[7:0]),
    .in_col    (s_tdata[13:8]),
    .in_row    (s_tdata[19:14]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_data  (out_data),
    .out_col   (out_col),
    .out_row   (out_row),
    .out_atc   (out_atc),
    .out_last  (m_tlast)
  );

  assign m_tdata = {3'b000, out_atc, out_row, out_col, out_data};

endmodule

### test/text_terminal_line_editor_unit_tb.sv
// Self-checking testbench for the text terminal line editor: scoreboard, stall and reconfig runs.
`timescale 1ns / 1ps

module text_terminal_line_editor_unit_tb;
  import tle_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int unsigned SCR_DEPTH = 1 << ADDR_W;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned QUIET_CYCLES = 80;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } term_req_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [COL_W-1:0]  ccol;
    logic [ROW_W-1:0]  crow;
    logic              atc;
    logic              last;
  } term_res_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata = '0;   // byte_req[7:0], col[13:8], row[19:14], zero pad
  logic [ACT_W-1:0]     s_tuser = '0;   // action[1:0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [23:0]          m_tdata;        // data[7:0], cursor_col[13:8], cursor_row[19:14],
                                        // at_cursor[20], zero pad
  logic [KIND_W-1:0]    m_tuser;        // kind[1:0]
  logic                 m_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  text_terminal_line_editor_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Terminal mirror
  logic [BYTE_W-1:0] scr_mem [0:SCR_DEPTH-1];
  logic [BYTE_W-1:0] line_buf [0:LINE_MAX-1];
  logic [DIM_W-1:0]  reg_cols = COLS_RST;
  logic [DIM_W-1:0]  reg_rows = ROWS_RST;
  int unsigned       cur_x = 0;
  int unsigned       cur_y = 0;
  int unsigned       rot = 0;
  int unsigned       line_len = 0;

  term_req_t   req_q[$];
  term_res_t   due_q[$];
  int unsigned n_sent = 0;
  int unsigned n_taken = 0;
  int unsigned n_fail = 0;
  bit          steady = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;

  function automatic int unsigned eff_cols();
    if (reg_cols < 1) return 1;
    if (reg_cols > MAX_COLS) return MAX_COLS;
    return reg_cols;
  endfunction

  function automatic int unsigned eff_rows();
    if (reg_rows < 1) return 1;
    if (reg_rows > MAX_ROWS) return MAX_ROWS;
    return reg_rows;
  endfunction

  function automatic int unsigned scr_addr(int unsigned x, int unsigned y);
    return (((y + rot) % eff_rows()) * MAX_COLS + x) % SCR_DEPTH;
  endfunction

  function automatic void cursor_down();
    int unsigned h;
    h = eff_rows();
    cur_y++;
    if (cur_y >= h) begin
      rot = (rot + 1) % h;
      cur_y = h - 1;
      for (int unsigned i = 0; i < eff_cols(); i++) scr_mem[scr_addr(i, h - 1)] = '0;
    end
  endfunction

  function automatic void cursor_right();
    cur_x++;
    if (cur_x >= eff_cols()) begin
      cursor_down();
      cur_x = 0;
    end
  endfunction

  function automatic void cursor_left();
    if (cur_x == 0) begin
      cur_x = eff_cols() - 1;
      if (cur_y > 0) cur_y--;
    end else begin
      cur_x--;
    end
  endfunction

  function automatic void print_char(logic [BYTE_W-1:0] c);
    if (c == CHR_CR) begin
      cur_x = 0;
    end else if (c == CHR_LF) begin
      cur_x = 0;
      cursor_down();
    end else if (c == CHR_BS) begin
      if (cur_x != 0) cursor_left();
    end else begin
      scr_mem[scr_addr(cur_x, cur_y)] = c;
      cursor_right();
    end
  endfunction

  function automatic void expect_result(kind_t k, logic [BYTE_W-1:0] d, logic atc, logic last);
    term_res_t r;
    r.kind = k;
    r.data = d;
    r.ccol = cur_x[COL_W-1:0];
    r.crow = cur_y[ROW_W-1:0];
    r.atc  = atc;
    r.last = last;
    due_q.push_back(r);
  endfunction

  // Update the mirror for one accepted item and queue the results it should produce.
  function automatic void terminal_step(term_req_t r);
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] d;
    logic              atc;
    int unsigned       n;
    c = r.code;
    if (r.action == ACT_PRINT) begin
      print_char(c);
    end else if (r.action == ACT_KEY) begin
      if (c == CHR_CR) c = CHR_LF;
      if (c == CHR_LF) begin
        n = line_len;
        line_len = 0;
        print_char(CHR_LF);
        for (int unsigned i = 0; i < n; i++) expect_result(KIND_CONSOLE, line_buf[i], 1'b0, 1'b0);
        expect_result(KIND_CONSOLE, CHR_LF, 1'b0, 1'b1);
        return;
      end else if (c == CHR_BS) begin
        if (line_len != 0) begin
          line_len--;
          // erase back to the previous filled cell
          do begin
            cursor_left();
            scr_mem[scr_addr(cur_x, cur_y)] = '0;
          end while (cur_x != 0 && scr_mem[scr_addr(cur_x - 1, cur_y)] == CHR_NUL);
        end
      end else if (c != CHR_NUL && line_len < LINE_MAX) begin
        line_buf[line_len] = c;
        line_len++;
        print_char(c);
      end
    end else if (r.action == ACT_READ) begin
      d = '0;
      atc = 1'b0;
      if (r.col < eff_cols() && r.row < eff_rows()) begin
        d = scr_mem[scr_addr(r.col, r.row)];
        atc = (r.col == cur_x && r.row == cur_y);
      end
      expect_result(KIND_CELL, d, atc, 1'b1);
      return;
    end
    expect_result(KIND_STATUS, '0, 1'b0, 1'b1);
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sender
  always @(posedge clk) begin
    term_req_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        r.action = s_tuser;
        r.code   = s_tdata[7:0];
        r.col    = s_tdata[13:8];
        r.row    = s_tdata[19:14];
        terminal_step(r);
        n_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (req_q.size() > 0 && (steady || $urandom_range(0, 99) >= 33)) begin
          r = req_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {4'b0, r.row, r.col, r.code};
          s_tuser  <= r.action;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver and result check
  always @(posedge clk) begin
    term_res_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_q.size() == 0) begin
          $error("unexpected result: kind %0d data %h", m_tuser, m_tdata[7:0]);
          n_fail++;
        end else begin
          e = due_q.pop_front();
          if (m_tuser !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, m_tuser);
            n_fail++;
          end
          if (m_tdata[7:0] !== e.data) begin
            $error("data: expected %h, got %h", e.data, m_tdata[7:0]);
            n_fail++;
          end
          if (m_tdata[13:8] !== e.ccol) begin
            $error("cursor_col: expected %0d, got %0d", e.ccol, m_tdata[13:8]);
            n_fail++;
          end
          if (m_tdata[19:14] !== e.crow) begin
            $error("cursor_row: expected %0d, got %0d", e.crow, m_tdata[19:14]);
            n_fail++;
          end
          if (m_tdata[20] !== e.atc) begin
            $error("at_cursor: expected %0d, got %0d", e.atc, m_tdata[20]);
            n_fail++;
          end
          if (m_tlast !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, m_tlast);
            n_fail++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_seen != hold_req) begin
        // long hold-off so the block backs up and stalls its input
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] code,
                      logic [COL_W-1:0] col = '0, logic [ROW_W-1:0] row = '0);
    term_req_t r;
    r.action = act;
    r.code   = code;
    r.col    = col;
    r.row    = row;
    req_q.push_back(r);
    n_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_COLUMNS) reg_cols = val;
    else reg_rows = val;
    if (cur_x >= eff_cols()) cur_x = eff_cols() - 1;
    if (cur_y >= eff_rows()) cur_y = eff_rows() - 1;
    rot = rot % eff_rows();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every item is taken and every result has arrived, then let the block settle.
  task automatic settle();
    do @(posedge clk);
    while (n_taken != n_sent || due_q.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_key();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 70) return BYTE_W'($urandom_range(8'h20, 8'h7E));
    if (p < 82) return CHR_BS;
    if (p < 92) return BYTE_W'($urandom_range(0, 255));
    return CHR_NUL;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_print();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return BYTE_W'($urandom_range(8'h20, 8'h7E));
    if (p < 70) return CHR_CR;
    if (p < 80) return CHR_LF;
    if (p < 90) return CHR_BS;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic key_line(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send(ACT_KEY, pick_key());
    send(ACT_KEY, $urandom_range(0, 1) ? CHR_CR : CHR_LF);
  endtask

  task automatic mixed(int unsigned count);
    int unsigned start;
    int unsigned p;
    start = n_sent;
    while (n_sent - start < count) begin
      p = $urandom_range(0, 99);
      if (p < 40) begin
        key_line($urandom_range(0, 9) == 0 ? $urandom_range(20, 40) : $urandom_range(0, 10));
      end else if (p < 65) begin
        repeat ($urandom_range(1, 8)) send(ACT_PRINT, pick_print());
      end else if (p < 90) begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 3) == 0)
            send(ACT_READ, BYTE_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 63)),
                 ROW_W'($urandom_range(0, 63)));
          else
            send(ACT_READ, '0, COL_W'($urandom_range(0, eff_cols() - 1)),
                 ROW_W'($urandom_range(0, eff_rows() - 1)));
        end
      end else begin
        // raw noise over every field, spare action included
        repeat ($urandom_range(1, 3))
          send(ACT_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
               COL_W'($urandom_range(0, 63)), ROW_W'($urandom_range(0, 63)));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SCR_DEPTH; i++) scr_mem[i] = '0;
    for (int i = 0; i < LINE_MAX; i++) line_buf[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: 4 x 3 screen so wrap, scroll and erase show up quickly
    write_reg(REG_COLUMNS, 7'd4);
    write_reg(REG_ROWS, 7'd3);
    send(ACT_PRINT, "H");
    send(ACT_PRINT, 8'hFF);
    send(ACT_PRINT, CHR_NUL);
    send(ACT_PRINT, "I");
    send(ACT_PRINT, CHR_BS);
    send(ACT_PRINT, "a");
    send(ACT_PRINT, CHR_BS);
    send(ACT_PRINT, CHR_CR);
    send(ACT_PRINT, CHR_LF);
    send(ACT_PRINT, CHR_LF);
    send(ACT_PRINT, CHR_LF);
    send(ACT_SPARE, 8'hFF, 6'd63, 6'd63);
    send(ACT_KEY, CHR_NUL);
    send(ACT_KEY, CHR_BS);
    send(ACT_KEY, "p");
    send(ACT_KEY, "q");
    send(ACT_KEY, "r");
    send(ACT_KEY, "s");
    send(ACT_KEY, CHR_BS);
    send(ACT_KEY, CHR_BS);
    send(ACT_KEY, CHR_CR);
    send(ACT_KEY, CHR_LF);
    send(ACT_READ, '0, 6'd0, 6'd0);
    send(ACT_READ, '0, 6'd0, 6'd2);
    send(ACT_READ, '0, 6'd63, 6'd63);
    send(ACT_READ, '0, 6'd3, 6'd1);
    settle();

    // widest, single row: every newline scrolls
    write_reg(REG_COLUMNS, 7'd127);
    write_reg(REG_ROWS, 7'd0);
    mixed(45);
    settle();

    write_reg(REG_COLUMNS, 7'd1);
    write_reg(REG_ROWS, 7'd64);
    mixed(35);
    settle();

    // full line: overflow keys are dropped, enter emits the longest burst under a stall
    write_reg(REG_COLUMNS, 7'd64);
    write_reg(REG_ROWS, 7'd127);
    hold_req++;
    repeat (66) send(ACT_KEY, BYTE_W'($urandom_range(8'h21, 8'h7E)));
    send(ACT_KEY, CHR_CR);
    settle();

    write_reg(REG_COLUMNS, 7'd0);
    write_reg(REG_ROWS, 7'd1);
    steady = 1'b1;
    mixed(30);
    settle();
    steady = 1'b0;

    write_reg(REG_COLUMNS, DIM_W'($urandom_range(2, 64)));
    write_reg(REG_ROWS, DIM_W'($urandom_range(2, 64)));
    mixed(35);
    settle();

    write_reg(REG_ROWS, DIM_W'($urandom_range(2, 64)));
    write_reg(REG_COLUMNS, DIM_W'($urandom_range(2, 64)));
    mixed(35);
    settle();

    if (n_fail == 0 && due_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
